>>> sv/orbd_pkg.sv
// ----------------------------------------------------------------------------
// orbd_pkg
// Shared sizes and operation codes for the overwriting ring buffer deque.
// ----------------------------------------------------------------------------
package orbd_pkg;

	// ring storage
	localparam int DEPTH      = 1024;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 64;

	// fixed field widths of the ports
	localparam int OP_W       = 3;
	localparam int INDEX_W    = 10;
	localparam int SIZE_W     = 11;
	localparam int OUT_CNT_W  = 11;

	// size register value after reset, before saturation to DEPTH
	localparam int SIZE_RESET = 1024;

	// operation codes
	localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_NEW   = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_OLD   = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK_OLD  = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_NEW  = 3'd4;

endpackage

>>> sv/orbd_ram.sv
// ----------------------------------------------------------------------------
// orbd_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module orbd_ram #(
	parameter int DEPTH_P = 1024,
	parameter int WIDTH_P = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH_P)-1:0] addr,
	input  logic [WIDTH_P-1:0]         wdata,
	output logic [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	// write and registered read share the one port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/overwriting_ring_buffer_deque.sv
// A result strobes on done in the cycle after its start transfer.
// Throughput: one operation per cycle; the single RAM port does at most one access per op.
// busy stays low, cfg_ready stays high; the receiver cannot stall results.
// Reset clears pointers, counts and full flag and sets the size to 1024
// (saturated to the ring depth); RAM contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_deque
// Ring buffer of 64-bit words in one RAM: overwriting write, pop newest or
// oldest, peek from either end. Writing the size register empties the buffer.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_deque (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic [orbd_pkg::OP_W-1:0]          operation,
	input  logic [orbd_pkg::DATA_W-1:0]        data_in,
	input  logic [orbd_pkg::INDEX_W-1:0]       index,
	// result channel
	output logic                               done,
	output logic [orbd_pkg::DATA_W-1:0]        data_out,
	output logic                               ok,
	output logic [orbd_pkg::OUT_CNT_W-1:0]     used_count,
	output logic [orbd_pkg::OUT_CNT_W-1:0]     free_count,
	output logic                               full_res,
	// size register write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [orbd_pkg::SIZE_W-1:0]        size_in_use
);

	localparam int PTR_W = orbd_pkg::PTR_W;
	localparam int CNT_W = orbd_pkg::CNT_W;
	localparam int CMP_W = (CNT_W > orbd_pkg::SIZE_W) ? CNT_W : orbd_pkg::SIZE_W;
	localparam int IDX_CMP_W = (CNT_W > orbd_pkg::INDEX_W) ? CNT_W : orbd_pkg::INDEX_W;
	localparam int SIZE_RST = (orbd_pkg::DEPTH < orbd_pkg::SIZE_RESET) ?
		orbd_pkg::DEPTH : orbd_pkg::SIZE_RESET;

	// slot lying back steps before newest, wrapped within size s (back < s)
	function automatic logic [PTR_W-1:0] back_from_newest(
		input logic [PTR_W-1:0] n,
		input logic [CNT_W-1:0] back,
		input logic [CNT_W-1:0] s
	);
		logic [CNT_W:0] t;
		t = (CNT_W+1)'(n);
		if (t >= (CNT_W+1)'(back)) begin
			t = t - (CNT_W+1)'(back);
		end else begin
			t = t + (CNT_W+1)'(s) - (CNT_W+1)'(back);
		end
		return PTR_W'(t);
	endfunction

	// state
	logic [CNT_W-1:0] size_q;
	logic [PTR_W-1:0] newest_q;
	logic [PTR_W-1:0] next_q;
	logic [CNT_W-1:0] held_q;
	logic             full_q;

	// result stage
	logic                              done_s1;
	logic                              ok_s1;
	logic                              rd_s1;
	logic [orbd_pkg::OUT_CNT_W-1:0]    used_s1;
	logic [orbd_pkg::OUT_CNT_W-1:0]    free_s1;
	logic                              full_s1;

	// next-state and RAM access
	logic                     accept;
	logic                     cfg_xfer;
	logic [CNT_W-1:0]         eff_size;
	logic [PTR_W-1:0]         newest_d;
	logic [PTR_W-1:0]         next_d;
	logic [CNT_W-1:0]         held_d;
	logic                     full_d;
	logic                     ok_d;
	logic                     mem_we;
	logic                     mem_re;
	logic [PTR_W-1:0]         mem_addr;
	logic [orbd_pkg::DATA_W-1:0] mem_rdata;
	logic                     idx_in_range;
	logic [CNT_W-1:0]         idx_c;
	logic [CNT_W-1:0]         held_m1;
	logic [CNT_W:0]           next_inc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	// size register saturated to 1..DEPTH
	always_comb begin
		if (size_in_use == '0) begin
			eff_size = CNT_W'(1);
		end else if (CMP_W'(size_in_use) > CMP_W'(orbd_pkg::DEPTH)) begin
			eff_size = CNT_W'(orbd_pkg::DEPTH);
		end else begin
			eff_size = CNT_W'(size_in_use);
		end
	end

	assign idx_in_range = IDX_CMP_W'(index) < IDX_CMP_W'(held_q);
	assign idx_c        = CNT_W'(index);
	assign held_m1      = held_q - CNT_W'(1);
	assign next_inc     = (CNT_W+1)'(next_q) + (CNT_W+1)'(1);

	// operation decode: pointer/count update and RAM address
	always_comb begin
		newest_d = newest_q;
		next_d   = next_q;
		held_d   = held_q;
		full_d   = full_q;
		ok_d     = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = next_q;
		unique case (operation)
			orbd_pkg::OP_WRITE: begin
				mem_we   = accept;
				mem_addr = next_q;
				newest_d = next_q;
				next_d   = (next_inc >= (CNT_W+1)'(size_q)) ? '0 : PTR_W'(next_inc);
				if (held_q + CNT_W'(1) >= size_q) begin
					held_d = size_q;
					full_d = 1'b1;
				end else begin
					held_d = held_q + CNT_W'(1);
				end
				ok_d = 1'b1;
			end
			orbd_pkg::OP_POP_NEW: begin
				if (held_q != '0) begin
					mem_re   = accept;
					mem_addr = newest_q;
					next_d   = newest_q;
					newest_d = (newest_q == '0) ? PTR_W'(size_q - CNT_W'(1))
						: newest_q - PTR_W'(1);
					held_d   = held_m1;
					full_d   = 1'b0;
					ok_d     = 1'b1;
				end
			end
			orbd_pkg::OP_POP_OLD: begin
				if (held_q != '0) begin
					mem_re   = accept;
					mem_addr = back_from_newest(newest_q, held_m1, size_q);
					held_d   = held_m1;
					full_d   = 1'b0;
					ok_d     = 1'b1;
				end
			end
			orbd_pkg::OP_PEEK_OLD: begin
				if (idx_in_range) begin
					mem_re   = accept;
					mem_addr = back_from_newest(newest_q, held_m1 - idx_c, size_q);
					ok_d     = 1'b1;
				end
			end
			orbd_pkg::OP_PEEK_NEW: begin
				if (idx_in_range) begin
					mem_re   = accept;
					mem_addr = back_from_newest(newest_q, idx_c, size_q);
					ok_d     = 1'b1;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// state registers; a size write empties the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= CNT_W'(SIZE_RST);
			newest_q <= '0;
			next_q   <= '0;
			held_q   <= '0;
			full_q   <= 1'b0;
		end else if (cfg_xfer) begin
			size_q   <= eff_size;
			newest_q <= '0;
			next_q   <= '0;
			held_q   <= '0;
			full_q   <= 1'b0;
		end else if (accept) begin
			newest_q <= newest_d;
			next_q   <= next_d;
			held_q   <= held_d;
			full_q   <= full_d;
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			rd_s1   <= 1'b0;
		end else begin
			done_s1 <= accept;
			rd_s1   <= mem_re;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= ok_d;
			used_s1 <= orbd_pkg::OUT_CNT_W'(held_d);
			free_s1 <= orbd_pkg::OUT_CNT_W'(size_q - held_d);
			full_s1 <= full_d;
		end
	end

	orbd_ram #(
		.DEPTH_P (orbd_pkg::DEPTH),
		.WIDTH_P (orbd_pkg::DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (data_in),
		.rdata (mem_rdata)
	);

	assign done       = done_s1;
	assign data_out   = rd_s1 ? mem_rdata : '0;
	assign ok         = ok_s1;
	assign used_count = used_s1;
	assign free_count = free_s1;
	assign full_res   = full_s1;

	// held count never exceeds the size in use
	a_held_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= size_q)
		else $error("held count above size in use");

	// full flag tracks held == size
	a_full_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (held_q == size_q))
		else $error("full flag out of step with held count");

	// pointers stay inside the ring in use
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W'(newest_q) < size_q) && (CNT_W'(next_q) < size_q))
		else $error("slot pointer beyond size in use");

	// a RAM read is only issued for a successful pop or peek
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (done_s1 && ok_s1))
		else $error("read data returned without a successful op");

	// every write transfer reports ok
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == orbd_pkg::OP_WRITE) |=> (done && ok))
		else $error("write not reported as ok");

endmodule
